// File: hdl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame decoder.
package lpfd_pkg;

    // Input word kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Header layout: four id bytes, then four length bytes
    localparam int          HDR_CW      = 3;
    localparam logic [2:0]  HDR_ID_LAST = 3'd3;
    localparam logic [2:0]  HDR_LAST    = 3'd7;

    // Configuration
    localparam int          LEN_W             = 31;
    localparam logic [30:0] MAX_PAYLOAD_RESET = 31'd65536;

    // Result queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One result word
    typedef struct packed {
        logic               byte_valid;
        logic [7:0]         payload_byte;
        logic               frame_end;
        logic signed [31:0] frame_id;
        logic [LEN_W-1:0]   frame_length;
        logic               failed;
    } t_result;

    // Front to queue
    typedef struct packed {
        logic    push;
        t_result data;
    } t_q_wr;

    // Queue status to front and back
    typedef struct packed {
        logic    full;
        logic    head_valid;
        t_result head;
    } t_q_stat;

endpackage

// File: hdl/lpfd_if.sv
// Stream interfaces for the decoder input and result channels.
interface lpfd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface lpfd_out_if;
    logic               valid;
    logic               ready;
    logic               byte_valid;
    logic [7:0]         payload_byte;
    logic               frame_end;
    logic signed [31:0] frame_id;
    logic [30:0]        frame_length;
    logic               failed;

    modport source (output valid, output byte_valid, output payload_byte,
                    output frame_end, output frame_id, output frame_length,
                    output failed, input ready);
    modport sink   (input valid, input byte_valid, input payload_byte,
                    input frame_end, input frame_id, input frame_length,
                    input failed, output ready);
endinterface

// File: hdl/lpfd_front.sv
// Front end: header parser, payload counter and failure flag; one result per word.
module lpfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [30:0]      i_cfg_wr_data,
    lpfd_in_if.sink          i_in,
    input  lpfd_pkg::t_q_stat i_q_stat,
    output lpfd_pkg::t_q_wr  o_q_wr
);
    import lpfd_pkg::*;

    logic [LEN_W-1:0]  r_max, n_max;
    logic [HDR_CW-1:0] r_hcount, n_hcount;
    logic [31:0]       r_id, n_id;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_left, n_left;
    logic              r_in_payload, n_in_payload;
    logic              r_failed, n_failed;

    logic              accept;
    logic              do_clear;
    logic [LEN_W-1:0]  hdr_len;
    t_result           res;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    // Full length field as it completes on the last header byte
    assign hdr_len = {i_in.data_byte[6:0], r_len[23:0]};

    // Next state and result word
    always_comb begin
        n_max        = i_cfg_wr_en ? i_cfg_wr_data : r_max;
        n_hcount     = r_hcount;
        n_id         = r_id;
        n_len        = r_len;
        n_left       = r_left;
        n_in_payload = r_in_payload;
        n_failed     = r_failed;
        do_clear     = 1'b0;
        res          = '0;

        if (accept) begin
            if (i_in.kind == KIND_CLEAR) begin
                do_clear = 1'b1;
                n_failed = 1'b0;
            end else if (r_failed) begin
                // bytes dropped until a clear word
            end else if (r_in_payload) begin
                res.byte_valid   = 1'b1;
                res.payload_byte = i_in.data_byte;
                res.frame_id     = r_id;
                res.frame_length = r_len;
                n_left           = r_left - LEN_W'(1);
                if (r_left == LEN_W'(1)) begin
                    res.frame_end = 1'b1;
                    do_clear      = 1'b1;
                end
            end else begin
                n_hcount = r_hcount + HDR_CW'(1);
                case (r_hcount)
                    3'd0: begin
                        n_id  = {24'd0, i_in.data_byte};
                        n_len = '0;
                    end
                    3'd1: n_id[15:8]  = i_in.data_byte;
                    3'd2: n_id[23:16] = i_in.data_byte;
                    3'd3: n_id[31:24] = i_in.data_byte;
                    3'd4: n_len[7:0]  = i_in.data_byte;
                    3'd5: n_len[15:8] = i_in.data_byte;
                    3'd6: n_len[23:16] = i_in.data_byte;
                    default: begin
                        // last header byte: check the length
                        if (i_in.data_byte[7] || hdr_len > r_max) begin
                            n_failed = 1'b1;
                            do_clear = 1'b1;
                        end else if (hdr_len == '0) begin
                            res.frame_end = 1'b1;
                            res.frame_id  = r_id;
                            do_clear      = 1'b1;
                        end else begin
                            n_in_payload = 1'b1;
                            n_left       = hdr_len;
                            n_len        = hdr_len;
                        end
                    end
                endcase
            end
        end

        if (do_clear) begin
            n_hcount     = '0;
            n_id         = '0;
            n_len        = '0;
            n_left       = '0;
            n_in_payload = 1'b0;
        end

        res.failed = n_failed;
    end

    assign o_q_wr.push = accept;
    assign o_q_wr.data = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= MAX_PAYLOAD_RESET;
            r_hcount     <= '0;
            r_id         <= '0;
            r_len        <= '0;
            r_left       <= '0;
            r_in_payload <= 1'b0;
            r_failed     <= 1'b0;
        end else begin
            r_max        <= n_max;
            r_hcount     <= n_hcount;
            r_id         <= n_id;
            r_len        <= n_len;
            r_left       <= n_left;
            r_in_payload <= n_in_payload;
            r_failed     <= n_failed;
        end
    end

`ifndef NO_ASSERTIONS
    // A clear word leaves no failure and no partial frame
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.kind == KIND_CLEAR |=>
        !r_failed && !r_in_payload && r_hcount == '0)
        else $error("clear word did not reset frame state");

    // Payload counter is never zero inside a frame
    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> r_left != '0 && r_hcount == '0)
        else $error("payload state inconsistent");

    // While failed, no frame is in progress
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !r_in_payload && r_hcount == '0)
        else $error("frame in progress while failed");
`endif

endmodule

// File: hdl/lpfd_queue.sv
// Short result queue decoupling the parser from the output stage.
module lpfd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpfd_pkg::t_q_wr   i_wr,
    input  logic              i_pop,
    output lpfd_pkg::t_q_stat o_stat
);
    import lpfd_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;

    // Pointers wrap naturally since the depth is a power of two
    always_comb begin
        n_wr_ptr = i_wr.push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = i_pop     ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count + QUEUE_CW'(i_wr.push) - QUEUE_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_stat.full       = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.head_valid = (r_count != '0);
    assign o_stat.head       = r_mem[r_rd_ptr];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_wr.push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a word");
`endif

endmodule

// File: hdl/lpfd_back.sv
// Back end: output register that drives the result channel from the queue head.
module lpfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpfd_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    lpfd_out_if.source        o_out
);
    import lpfd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;
    logic    take;

    // Load a new word when the register is empty or being drained
    assign take  = !r_valid || o_out.ready;
    assign o_pop = take && i_q_stat.head_valid;

    always_comb begin
        n_valid = take ? i_q_stat.head_valid : r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_stat.head;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.byte_valid   = r_data.byte_valid;
    assign o_out.payload_byte = r_data.payload_byte;
    assign o_out.frame_end    = r_data.frame_end;
    assign o_out.frame_id     = r_data.frame_id;
    assign o_out.frame_length = r_data.frame_length;
    assign o_out.failed       = r_data.failed;

endmodule

// File: hdl/length_prefixed_frame_decoder.sv
// Length-prefixed frame decoder: one result word per input word.
// An accepted word's result is written into the result queue, then loaded into the output register.
// Throughput: one word per cycle, set by the header parser, while the result queue is not full.
// A four-word result queue lets input and output stall independently.
// Reset (synchronous, active low) clears the parser, the failure flag and
// the queue, and sets max_payload to 65536; no clearing pass is needed.
module length_prefixed_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [30:0] i_cfg_wr_data,
    lpfd_in_if.sink     i_in,
    lpfd_out_if.source  o_out
);
    import lpfd_pkg::*;

    t_q_wr   q_wr;
    t_q_stat q_stat;
    logic    q_pop;

    lpfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_stat      (q_stat),
        .o_q_wr        (q_wr)
    );

    lpfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    lpfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

endmodule
